// ----- hw/rtl/image_histogram_statistics_macros.svh -----
// ----------------------------------------------------------------------------
// Image histogram statistics: assertion macros
// Concurrent assertion wrappers shared by the design files. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IMAGE_HISTOGRAM_STATISTICS_MACROS_SVH
`define IMAGE_HISTOGRAM_STATISTICS_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define IHS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// The condition must never be true outside reset.
`define IHS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define IHS_ASSERT(label, clk, rst, prop, msg)

`define IHS_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ----- hw/rtl/ihs_pkg.sv -----
// ----------------------------------------------------------------------------
// Image histogram statistics package
// Payload types and fixed field widths shared by the design files.
// ----------------------------------------------------------------------------
package ihs_pkg;

   localparam int PIXEL_W    = 8;
   localparam int NUM_LEVELS = 256;
   localparam int COUNT_W    = 25;
   localparam int SUM_W      = 32;
   localparam int MEAN_W     = 16;
   localparam int FRAC_W     = 8;
   localparam int DIVIDEND_W = SUM_W + FRAC_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [PIXEL_W-1:0] MIN_RESET = 8'd255;
   localparam logic [PIXEL_W-1:0] MAX_RESET = 8'd0;
   localparam logic [PIXEL_W-1:0] MEDIAN_NONE = 8'd255;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } ihs_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] pixel_count;
      logic [SUM_W-1:0]   intensity_total;
      logic [PIXEL_W-1:0] min_value;
      logic [PIXEL_W-1:0] max_value;
      logic [PIXEL_W-1:0] median_value;
      logic [MEAN_W-1:0]  mean_q8;
   } ihs_rsp_type;

endpackage

// ----- hw/rtl/ihs_bin_ram.sv -----
// ----------------------------------------------------------------------------
// Histogram bin memory
// One bin per gray level, one write and one read port, registered read data
// with read-before-write on the same address.
// ----------------------------------------------------------------------------
module ihs_bin_ram #(
   parameter int DATA_W = 24
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [ihs_pkg::PIXEL_W-1:0] rd_addr,
   output logic [DATA_W-1:0]          rd_data,
   input  logic                       wr_en,
   input  logic [ihs_pkg::PIXEL_W-1:0] wr_addr,
   input  logic [DATA_W-1:0]          wr_data
);
   import ihs_pkg::*;

   logic [DATA_W-1:0] mem [NUM_LEVELS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ihs_mean_div.sv -----
// ----------------------------------------------------------------------------
// Mean divider
// Restoring divider, one quotient bit per cycle, computing
// floor(sum * 256 / count) and saturating the result to 16 bits.
// ----------------------------------------------------------------------------
module ihs_mean_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ihs_pkg::SUM_W-1:0]   dividend,
   input  logic [ihs_pkg::COUNT_W-1:0] divisor,
   output logic                        done,
   output logic [ihs_pkg::MEAN_W-1:0]  quotient
);
   import ihs_pkg::*;

   localparam int REM_W = COUNT_W + 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [COUNT_W-1:0]    div_ff, div_in;
   // Dividend bits shift out at the top while quotient bits shift in below.
   logic [DIVIDEND_W-1:0] num_ff, num_in;

   logic [REM_W-1:0] trial;
   logic             fits;

   always_comb begin
      trial = {rem_ff, num_ff[DIVIDEND_W-1]};
      fits  = trial >= REM_W'(div_ff);

      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      num_in  = num_ff;

      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         rem_in  = '0;
         div_in  = divisor;
         num_in  = {dividend, {FRAC_W{1'b0}}};
      end else if (busy_ff) begin
         rem_in  = fits ? COUNT_W'(trial - REM_W'(div_ff)) : trial[COUNT_W-1:0];
         num_in  = {num_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      num_ff <= num_in;
   end

   assign done     = done_ff;
   assign quotient = (|num_ff[DIVIDEND_W-1:MEAN_W]) ? '1 : num_ff[MEAN_W-1:0];

endmodule

// ----- hw/rtl/image_histogram_statistics.sv -----
// ----------------------------------------------------------------------------
// Image histogram statistics
// Pixels of a frame are accepted one per cycle while req_ready is high. The
// result with count, sum, min, max, median and mean is loaded after the last
// pixel's transfer, the drain state, the bin scan and the mean division; until
// then req_ready stays low. The scan reads and zeroes all 256 bins, one per
// cycle. After reset a pass zeroes the bin memory with req_ready held low.
// ----------------------------------------------------------------------------
`include "image_histogram_statistics_macros.svh"

module image_histogram_statistics #(
   parameter int COUNT_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ihs_pkg::ihs_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ihs_pkg::ihs_rsp_type rsp_data
);
   import ihs_pkg::*;

   localparam int CUM_W = COUNT_BITS + PIXEL_W;
   localparam int CMP_W = (CUM_W > COUNT_W) ? CUM_W : COUNT_W;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_RUN    = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic [PIXEL_W-1:0]    s1_addr_ff, s1_addr_in;
   logic                  fwd_vld_ff;
   logic [PIXEL_W-1:0]    fwd_addr_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [COUNT_W-1:0]    count_acc_ff, count_acc_in;
   logic [SUM_W-1:0]      sum_acc_ff, sum_acc_in;
   logic [PIXEL_W-1:0]    min_acc_ff, min_acc_in;
   logic [PIXEL_W-1:0]    max_acc_ff, max_acc_in;
   logic [PIXEL_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                  scan_done_ff, scan_done_in;
   logic                  scan_vld_ff;
   logic [PIXEL_W-1:0]    scan_idx_ff;
   logic [CUM_W-1:0]      cum_ff, cum_in;
   logic                  found_ff, found_in;
   logic [PIXEL_W-1:0]    median_ff, median_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ihs_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  scan_issue;
   logic                  clear_issue;
   logic                  rsp_load;
   logic [COUNT_BITS-1:0] bin_cur;
   logic [COUNT_BITS-1:0] bin_inc;
   logic [SUM_W:0]        sum_ext;
   logic [CUM_W-1:0]      cum_new;
   logic                  cum_hit;

   logic                  ram_rd_en;
   logic [PIXEL_W-1:0]    ram_rd_addr;
   logic [COUNT_BITS-1:0] ram_rd_data;
   logic                  ram_wr_en;
   logic [PIXEL_W-1:0]    ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;

   logic                  div_start;
   logic                  div_done;
   logic [MEAN_W-1:0]     div_quotient;

   ihs_bin_ram #(
      .DATA_W (COUNT_BITS)
   ) u_bin_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   ihs_mean_div u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_acc_ff),
      .divisor  (count_acc_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready   = (state_ff == ST_RUN);
   assign req_fire    = req_valid && req_ready;
   assign scan_issue  = (state_ff == ST_SCAN) && !scan_done_ff;
   assign clear_issue = (state_ff == ST_CLEAR);
   assign div_start   = (state_ff == ST_DRAIN);
   assign rsp_load    = (state_ff == ST_FINISH) && div_done && (!rsp_valid_ff || rsp_ready);

   // The read of the current pixel happened at the same edge as the previous
   // pixel's write, so a bin updated back to back comes from the forward path.
   assign bin_cur = (fwd_vld_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rd_data;
   assign bin_inc = (&bin_cur) ? bin_cur : bin_cur + COUNT_BITS'(1);

   // Both the reset pass and the scan write zeros; the scan reads the same bin.
   assign ram_wr_en   = s1_vld_ff || scan_issue || clear_issue;
   assign ram_wr_addr = s1_vld_ff ? s1_addr_ff : scan_addr_ff;
   assign ram_wr_data = s1_vld_ff ? bin_inc : '0;
   assign ram_rd_en   = req_fire || scan_issue;
   assign ram_rd_addr = scan_issue ? scan_addr_ff : req_data.pixel;

   assign sum_ext = {1'b0, sum_acc_ff} + (SUM_W + 1)'(req_data.pixel);
   assign cum_new = cum_ff + CUM_W'(ram_rd_data);
   assign cum_hit = CMP_W'(cum_new) > CMP_W'(count_acc_ff >> 1);

   always_comb begin
      state_in     = state_ff;
      s1_vld_in    = req_fire;
      s1_addr_in   = req_data.pixel;
      count_acc_in = count_acc_ff;
      sum_acc_in   = sum_acc_ff;
      min_acc_in   = min_acc_ff;
      max_acc_in   = max_acc_ff;
      scan_addr_in = scan_addr_ff;
      scan_done_in = scan_done_ff;
      cum_in       = cum_ff;
      found_in     = found_ff;
      median_in    = median_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (req_fire) begin
         if (count_acc_ff != COUNT_MAX) begin
            count_acc_in = count_acc_ff + 1'b1;
         end
         sum_acc_in = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
         if (req_data.pixel < min_acc_ff) begin
            min_acc_in = req_data.pixel;
         end
         if (req_data.pixel > max_acc_ff) begin
            max_acc_in = req_data.pixel;
         end
      end

      if (scan_vld_ff) begin
         cum_in = cum_new;
         if (!found_ff && cum_hit) begin
            found_in  = 1'b1;
            median_in = scan_idx_ff;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            scan_addr_in = scan_addr_ff + 1'b1;
            if (&scan_addr_ff) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (req_fire && req_data.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The drain state lets the last pixel's bin write land before the scan reads.
            cum_in       = '0;
            found_in     = 1'b0;
            median_in    = MEDIAN_NONE;
            scan_done_in = 1'b0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_issue) begin
               scan_addr_in = scan_addr_ff + 1'b1;
               if (&scan_addr_ff) begin
                  scan_done_in = 1'b1;
               end
            end
            if (scan_done_ff && !scan_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.pixel_count      = count_acc_ff;
               rsp_data_in.intensity_total  = sum_acc_ff;
               rsp_data_in.min_value        = min_acc_ff;
               rsp_data_in.max_value        = max_acc_ff;
               rsp_data_in.median_value     = median_ff;
               rsp_data_in.mean_q8          = div_quotient;
               count_acc_in                 = '0;
               sum_acc_in                   = '0;
               min_acc_in                   = MIN_RESET;
               max_acc_in                   = MAX_RESET;
               state_in                     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         s1_vld_ff    <= 1'b0;
         fwd_vld_ff   <= 1'b0;
         count_acc_ff <= '0;
         sum_acc_ff   <= '0;
         min_acc_ff   <= MIN_RESET;
         max_acc_ff   <= MAX_RESET;
         scan_addr_ff <= '0;
         scan_done_ff <= 1'b0;
         scan_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= s1_vld_in;
         fwd_vld_ff   <= s1_vld_ff;
         count_acc_ff <= count_acc_in;
         sum_acc_ff   <= sum_acc_in;
         min_acc_ff   <= min_acc_in;
         max_acc_ff   <= max_acc_in;
         scan_addr_ff <= scan_addr_in;
         scan_done_ff <= scan_done_in;
         scan_vld_ff  <= scan_issue;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_addr_ff  <= s1_addr_in;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= bin_inc;
      scan_idx_ff <= scan_addr_ff;
      cum_ff      <= cum_in;
      median_ff   <= median_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `IHS_ASSERT(a_last_enters_drain, clock, reset, (req_fire && req_data.last) |=> (state_ff == ST_DRAIN), "last pixel transfer did not start the frame end")
   `IHS_ASSERT_NEVER(a_scan_no_update, clock, reset, (state_ff == ST_SCAN) && s1_vld_ff, "bin update overlaps the scan")
   `IHS_ASSERT_NEVER(a_finish_scan_empty, clock, reset, (state_ff == ST_FINISH) && scan_vld_ff, "frame end reached with scan data in flight")
   `IHS_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH), "result loaded outside the finish state")
   `IHS_ASSERT(a_rsp_min_max, clock, reset, rsp_valid_ff |-> (rsp_data_ff.min_value <= rsp_data_ff.max_value), "result minimum exceeds maximum")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image histogram statistics testbench
// Streams frames of 8-bit pixels into the block and checks every frame result
// (count, sum, min, max, median, mean) against a local histogram predictor.
// Both handshake sides idle at random, the result side holds off once for a
// long stretch, and before some frames the sender waits for all results.
// ----------------------------------------------------------------------------
module tb;
   import ihs_pkg::*;

   localparam int BIN_BITS      = 24;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 400;
   localparam int HOLD_CYCLES   = 700;
   localparam int TAIL_ITEMS    = 250;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int PRINT_CAP     = 40;
   localparam logic [BIN_BITS-1:0] BIN_FULL = '1;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_FLAT,
      SPREAD_EXTREME
   } pixel_style_type;

   typedef struct {
      ihs_req_type px;
      bit          drain_first;
   } pixel_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ihs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ihs_rsp_type rsp_data;

   image_histogram_statistics #(
      .COUNT_BITS(BIN_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // Frame state of the predictor.
   logic [BIN_BITS-1:0] bin_tally [NUM_LEVELS];
   logic [COUNT_W-1:0]  count_acc;
   logic [SUM_W-1:0]    total_acc;
   logic [PIXEL_W-1:0]  low_acc;
   logic [PIXEL_W-1:0]  high_acc;

   pixel_item_type pixel_queue [$];
   ihs_rsp_type    pending_stats [$];

   int unsigned pixels_queued = 0;
   int unsigned pixels_sent = 0;
   int unsigned frames_sent = 0;
   int unsigned results_seen = 0;
   int unsigned longest_frame = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sender_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   logic        quiet_tail = 1'b0;

   task automatic clear_frame();
      for (int g = 0; g < NUM_LEVELS; g++) begin
         bin_tally[g] = '0;
      end
      count_acc = '0;
      total_acc = '0;
      low_acc   = MIN_RESET;
      high_acc  = MAX_RESET;
   endtask

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("ERROR frame %0d: %s", results_seen, what);
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         flag_error($sformatf("%s got %0d, expected %0d", field, got, want));
      end
   endtask

   task automatic queue_pixel(input logic [PIXEL_W-1:0] px, input bit last,
                              input bit drain_first);
      pixel_item_type item;
      item.px.pixel    = px;
      item.px.last     = last;
      item.drain_first = drain_first;
      pixel_queue.push_back(item);
      pixels_queued++;
   endtask

   // Folds one pixel into the frame and, on the last pixel, predicts the
   // frame result and starts a fresh frame.
   task automatic accumulate_pixel(input ihs_req_type item);
      logic [39:0]        cum;
      logic [39:0]        quotient;
      logic [COUNT_W-1:0] half;
      ihs_rsp_type        stats;
      bit                 found;
      if (bin_tally[item.pixel] != BIN_FULL) begin
         bin_tally[item.pixel] = bin_tally[item.pixel] + 1'b1;
      end
      if (count_acc != COUNT_MAX) begin
         count_acc = count_acc + 1'b1;
      end
      if (total_acc > SUM_MAX - SUM_W'(item.pixel)) begin
         total_acc = SUM_MAX;
      end else begin
         total_acc = total_acc + SUM_W'(item.pixel);
      end
      if (item.pixel < low_acc) begin
         low_acc = item.pixel;
      end
      if (item.pixel > high_acc) begin
         high_acc = item.pixel;
      end
      if (item.last) begin
         stats.pixel_count     = count_acc;
         stats.intensity_total = total_acc;
         stats.min_value       = low_acc;
         stats.max_value       = high_acc;
         quotient = {total_acc, 8'h00} / 40'(count_acc);
         stats.mean_q8 = (quotient > 40'hFFFF) ? '1 : quotient[MEAN_W-1:0];
         // Walk the cumulative histogram; saturated bins may never pass half.
         half  = count_acc >> 1;
         cum   = '0;
         found = 1'b0;
         stats.median_value = MEDIAN_NONE;
         for (int g = 0; g < NUM_LEVELS; g++) begin
            if (!found) begin
               cum = cum + 40'(bin_tally[g]);
               if (cum > 40'(half)) begin
                  stats.median_value = 8'(g);
                  found = 1'b1;
               end
            end
         end
         pending_stats.push_back(stats);
         frames_sent++;
         if (count_acc > longest_frame) begin
            longest_frame = 32'(count_acc);
         end
         clear_frame();
      end
   endtask

   // Pixel driver.
   always @(posedge clock) begin : drive_pixels
      pixel_item_type head;
      logic           offer;
      bit             idling;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            accumulate_pixel(req_data);
            pixels_sent++;
            offer = 1'b0;
         end
         idling = !quiet_tail && ((pixels_sent / 160) % 2 == 0);
         if (!offer) begin
            if (sender_gap != 0) begin
               sender_gap--;
            end else if (idling && $urandom_range(0, 6) == 0) begin
               sender_gap = $urandom_range(0, 8);
            end else if (pixel_queue.size() != 0 &&
                         !(pixel_queue[0].drain_first && frames_sent != results_seen)) begin
               head = pixel_queue.pop_front();
               req_data <= head.px;
               offer = 1'b1;
            end
         end
         req_valid  <= offer;
         quiet_tail <= (pixel_queue.size() < TAIL_ITEMS);
      end
   end

   // Result side readiness, with one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 6) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && ((results_seen / 6) % 2 == 0) &&
                   $urandom_range(0, 3) == 0) begin
         rsp_stall = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result monitor.
   always @(posedge clock) begin : watch_results
      ihs_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            flag_error("result transfer with no frame outstanding");
         end else begin
            want = pending_stats.pop_front();
            compare_field("pixel_count", 32'(rsp_data.pixel_count), 32'(want.pixel_count));
            compare_field("intensity_total", rsp_data.intensity_total,
                          want.intensity_total);
            compare_field("min_value", 32'(rsp_data.min_value), 32'(want.min_value));
            compare_field("max_value", 32'(rsp_data.max_value), 32'(want.max_value));
            compare_field("median_value", 32'(rsp_data.median_value),
                          32'(want.median_value));
            compare_field("mean_q8", 32'(rsp_data.mean_q8), 32'(want.mean_q8));
         end
         results_seen <= results_seen + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d of %0d frames checked",
                  cycle_count, results_seen, frames_sent);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned     frame_no;
      int unsigned     len;
      int unsigned     base;
      int unsigned     spread;
      int unsigned     val;
      bit              drain;
      pixel_style_type style;
      logic [7:0]      px;

      clear_frame();

      // Directed frames: single pixels at both ends, a median that lands on
      // the top level, odd and even counts, and alternating bit patterns.
      queue_pixel(8'd0, 1'b1, 1'b0);
      queue_pixel(8'd255, 1'b1, 1'b1);
      queue_pixel(8'd0, 1'b0, 1'b0);
      queue_pixel(8'd255, 1'b1, 1'b0);
      queue_pixel(8'd255, 1'b0, 1'b0);
      queue_pixel(8'd0, 1'b0, 1'b0);
      queue_pixel(8'd128, 1'b0, 1'b0);
      queue_pixel(8'd128, 1'b0, 1'b0);
      queue_pixel(8'd7, 1'b1, 1'b0);
      queue_pixel(8'h55, 1'b0, 1'b0);
      queue_pixel(8'hAA, 1'b0, 1'b0);
      queue_pixel(8'h55, 1'b0, 1'b0);
      queue_pixel(8'hAA, 1'b1, 1'b0);
      queue_pixel(8'd200, 1'b0, 1'b0);
      queue_pixel(8'd200, 1'b0, 1'b0);
      queue_pixel(8'd200, 1'b0, 1'b0);
      queue_pixel(8'd1, 1'b0, 1'b0);
      queue_pixel(8'd254, 1'b0, 1'b0);
      queue_pixel(8'd100, 1'b1, 1'b0);

      // Random frames: mostly short, now and then a long one.
      frame_no = 0;
      while (pixels_queued < RANDOM_ITEMS + 19 || frame_no < 40) begin
         if ($urandom_range(0, 19) == 0) begin
            len = $urandom_range(200, 600);
         end else begin
            len = $urandom_range(1, 40);
         end
         style  = pixel_style_type'($urandom_range(0, 3));
         base   = $urandom_range(0, 255);
         spread = $urandom_range(1, 32);
         // Keep drain points clear of the long result hold-off.
         drain  = (frame_no >= 15) && ($urandom_range(0, 11) == 0);
         for (int k = 0; k < len; k++) begin
            case (style)
               SPREAD_FULL: begin
                  px = 8'($urandom_range(0, 255));
               end
               SPREAD_NARROW: begin
                  val = base + $urandom_range(0, spread);
                  px  = (val > 255) ? 8'd255 : 8'(val);
               end
               SPREAD_FLAT: begin
                  px = 8'(base);
               end
               default: begin
                  px = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
               end
            endcase
            queue_pixel(px, k == len - 1, drain && k == 0);
         end
         frame_no++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pixel_queue.size() != 0 || req_valid) @(posedge clock);
      while (results_seen != frames_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_stats.size() != 0) begin
         flag_error($sformatf("%0d frame results never arrived", pending_stats.size()));
      end

      $display("Checked %0d frames from %0d pixels; longest frame %0d pixels.",
               results_seen, pixels_sent, longest_frame);
      $display("Result side held off for %0d cycles once; %0d mismatches.",
               HOLD_CYCLES, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ihs_pkg.sv
hw/rtl/ihs_bin_ram.sv
hw/rtl/ihs_mean_div.sv
hw/rtl/image_histogram_statistics.sv
sim/tb.sv
